// ===== sv/tssp_pkg.sv =====
// ----------------------------------------------------------------------------
// tssp_pkg
// Types, constants and codes shared by the touch sample to screen point core.
// ----------------------------------------------------------------------------
package tssp_pkg;

  localparam int SAMPLE_W = 12;
  localparam int COORD_W  = 11;
  localparam int SUM_W    = SAMPLE_W + 2;
  localparam int NUM_W    = SAMPLE_W + COORD_W;
  localparam int DIV_STEPS = COORD_W;
  localparam int RECIP_W  = 16;
  localparam int RECIP_SH = 17;
  localparam int CFG_IDX_W = 3;

  // floor(n/3) == (n * 43691) >> 17 for n < 2^15
  localparam logic [RECIP_W-1:0] RECIP3 = 16'd43691;

  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 240;

  localparam logic [SAMPLE_W-1:0] RST_RAW_LEFT   = 12'd3800;
  localparam logic [SAMPLE_W-1:0] RST_RAW_RIGHT  = 12'd300;
  localparam logic [SAMPLE_W-1:0] RST_RAW_TOP    = 12'd3800;
  localparam logic [SAMPLE_W-1:0] RST_RAW_BOTTOM = 12'd300;
  localparam logic [COORD_W-1:0]  RST_ANCHOR_LOW    = 11'd0;
  localparam logic [COORD_W-1:0]  RST_ANCHOR_HIGH_X = 11'd319;
  localparam logic [COORD_W-1:0]  RST_ANCHOR_HIGH_Y = 11'd239;
  localparam logic [SAMPLE_W-1:0] RST_TOUCH_LEVEL = 12'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAW_LEFT        = 3'd0,
    REG_RAW_RIGHT       = 3'd1,
    REG_RAW_TOP         = 3'd2,
    REG_RAW_BOTTOM      = 3'd3,
    REG_ANCHOR_LOW      = 3'd4,
    REG_ANCHOR_HIGH_X   = 3'd5,
    REG_ANCHOR_HIGH_Y   = 3'd6,
    REG_TOUCH_LEVEL     = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MAP_LO_OUT = 2'd0,
    MAP_HI_OUT = 2'd1,
    MAP_DIV    = 2'd2
  } map_sel_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pressure_sample;
    logic [SAMPLE_W-1:0] x_sample_a;
    logic [SAMPLE_W-1:0] x_sample_b;
    logic [SAMPLE_W-1:0] x_sample_c;
    logic [SAMPLE_W-1:0] y_sample_a;
    logic [SAMPLE_W-1:0] y_sample_b;
    logic [SAMPLE_W-1:0] y_sample_c;
  } sample_t;

  typedef struct packed {
    logic               pressed;
    logic [COORD_W-1:0] screen_x;
    logic [COORD_W-1:0] screen_y;
  } point_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] raw_left;
    logic [SAMPLE_W-1:0] raw_right;
    logic [SAMPLE_W-1:0] raw_top;
    logic [SAMPLE_W-1:0] raw_bottom;
    logic [COORD_W-1:0]  anchor_low;
    logic [COORD_W-1:0]  anchor_high_x;
    logic [COORD_W-1:0]  anchor_high_y;
    logic [SAMPLE_W-1:0] touch_level;
  } cfg_t;

  typedef struct packed {
    map_sel_e           sel;
    logic               neg;
    logic [NUM_W-1:0]   rem;
    logic [NUM_W-1:0]   dvs;
    logic [COORD_W-1:0] quot;
  } axis_work_t;

  typedef struct packed {
    logic       pressed;
    axis_work_t x;
    axis_work_t y;
  } work_t;

endpackage

// ===== sv/tssp_prep.sv =====
// ----------------------------------------------------------------------------
// tssp_prep
// Pressure test, three-sample averages and setup of the anchored divide.
// ----------------------------------------------------------------------------
module tssp_prep import tssp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    up_valid,
  output logic    up_stall,
  input  sample_t up_sample,
  output logic    dn_valid,
  input  logic    dn_stall,
  output work_t   dn_work
);

  logic v1, v2, v3;
  logic hold1, hold2, hold3;
  logic                pressed1, pressed2;
  logic [SUM_W-1:0]    sum_x1, sum_y1;
  logic [SAMPLE_W-1:0] avg_x2, avg_y2;
  logic [SUM_W+RECIP_W-1:0] prod_x, prod_y;
  work_t work3;

  function automatic axis_work_t axis_setup(
    input logic [SAMPLE_W-1:0] v,
    input logic [SAMPLE_W-1:0] hi_raw,
    input logic [SAMPLE_W-1:0] lo_raw,
    input logic [COORD_W-1:0]  lo_out,
    input logic [COORD_W-1:0]  hi_out
  );
    axis_work_t          w;
    logic [SAMPLE_W-1:0] hv;
    logic [SAMPLE_W-1:0] span;
    logic [COORD_W-1:0]  dout;
    hv   = hi_raw - v;
    span = hi_raw - lo_raw;
    dout = (hi_out >= lo_out) ? (hi_out - lo_out) : (lo_out - hi_out);
    if (v >= hi_raw) begin
      w.sel = MAP_LO_OUT;
    end else if (v <= lo_raw) begin
      w.sel = MAP_HI_OUT;
    end else begin
      w.sel = MAP_DIV;
    end
    w.neg  = hi_out < lo_out;
    w.rem  = NUM_W'(hv) * NUM_W'(dout);
    w.dvs  = {1'b0, span, {(COORD_W-1){1'b0}}};
    w.quot = '0;
    return w;
  endfunction

  assign hold3    = v3 && dn_stall;
  assign hold2    = v2 && hold3;
  assign hold1    = v1 && hold2;
  assign up_stall = hold1;

  assign prod_x = (SUM_W+RECIP_W)'(sum_x1) * (SUM_W+RECIP_W)'(RECIP3);
  assign prod_y = (SUM_W+RECIP_W)'(sum_y1) * (SUM_W+RECIP_W)'(RECIP3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (!hold1) v1 <= up_valid;
      if (!hold2) v2 <= v1;
      if (!hold3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold1 && up_valid) begin
      pressed1 <= up_sample.pressure_sample >= cfg.touch_level;
      sum_x1 <= SUM_W'(up_sample.x_sample_a) + SUM_W'(up_sample.x_sample_b)
              + SUM_W'(up_sample.x_sample_c);
      sum_y1 <= SUM_W'(up_sample.y_sample_a) + SUM_W'(up_sample.y_sample_b)
              + SUM_W'(up_sample.y_sample_c);
    end
    if (!hold2 && v1) begin
      pressed2 <= pressed1;
      avg_x2   <= prod_x[RECIP_SH +: SAMPLE_W];
      avg_y2   <= prod_y[RECIP_SH +: SAMPLE_W];
    end
    if (!hold3 && v2) begin
      work3.pressed <= pressed2;
      work3.x <= axis_setup(avg_y2, cfg.raw_left, cfg.raw_right,
                            cfg.anchor_low, cfg.anchor_high_x);
      work3.y <= axis_setup(avg_x2, cfg.raw_top, cfg.raw_bottom,
                            cfg.anchor_low, cfg.anchor_high_y);
    end
  end

  assign dn_valid = v3;
  assign dn_work  = work3;

endmodule

// ===== sv/tssp_cell.sv =====
// ----------------------------------------------------------------------------
// tssp_cell
// One restoring divide step for both axes; one quotient bit per cell.
// ----------------------------------------------------------------------------
module tssp_cell import tssp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_stall,
  input  work_t up_work,
  output logic  dn_valid,
  input  logic  dn_stall,
  output work_t dn_work
);

  logic  valid;
  work_t work;
  work_t work_next;

  function automatic axis_work_t div_step(input axis_work_t w);
    axis_work_t r;
    logic       ge;
    r  = w;
    ge = w.rem >= w.dvs;
    if (ge) r.rem = w.rem - w.dvs;
    r.quot = {w.quot[COORD_W-2:0], ge};
    r.dvs  = w.dvs >> 1;
    return r;
  endfunction

  assign up_stall = valid && dn_stall;

  always_comb begin
    work_next         = up_work;
    work_next.x       = div_step(up_work.x);
    work_next.y       = div_step(up_work.y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) work <= work_next;
  end

  assign dn_valid = valid;
  assign dn_work  = work;

endmodule

// ===== sv/tssp_finish.sv =====
// ----------------------------------------------------------------------------
// tssp_finish
// Applies sign and low anchor, clamps divided results to the screen and holds the result.
// ----------------------------------------------------------------------------
module tssp_finish import tssp_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   up_valid,
  output logic   up_stall,
  input  work_t  up_work,
  output logic   point_valid,
  input  logic   point_stall,
  output point_t point
);

  localparam logic [COORD_W-1:0] LIM_X = COORD_W'(SCREEN_WIDTH - 1);
  localparam logic [COORD_W-1:0] LIM_Y = COORD_W'(SCREEN_HEIGHT - 1);

  logic   valid;
  point_t res;
  point_t res_next;

  function automatic logic [COORD_W-1:0] axis_finish(
    input axis_work_t          w,
    input logic [COORD_W-1:0]  lo_out,
    input logic [COORD_W-1:0]  hi_out,
    input logic [COORD_W-1:0]  lim
  );
    logic signed [COORD_W+1:0] q;
    logic signed [COORD_W+1:0] val;
    logic [COORD_W-1:0]        r;
    q   = $signed({2'b00, w.quot});
    val = $signed({2'b00, lo_out}) + (w.neg ? -q : q);
    unique case (w.sel)
      MAP_LO_OUT: r = lo_out;
      MAP_HI_OUT: r = hi_out;
      MAP_DIV: begin
        if (val < 0) begin
          r = '0;
        end else if (val > $signed({2'b00, lim})) begin
          r = lim;
        end else begin
          r = val[COORD_W-1:0];
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  assign up_stall = valid && point_stall;

  always_comb begin
    res_next.pressed = up_work.pressed;
    res_next.screen_x = '0;
    res_next.screen_y = '0;
    if (up_work.pressed) begin
      res_next.screen_x = axis_finish(up_work.x, cfg.anchor_low, cfg.anchor_high_x, LIM_X);
      res_next.screen_y = axis_finish(up_work.y, cfg.anchor_low, cfg.anchor_high_y, LIM_Y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) res <= res_next;
  end

  assign point_valid = valid;
  assign point       = res;

`ifndef SYNTHESIS
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    valid && !res.pressed |-> res.screen_x == '0 && res.screen_y == '0)
    else $error("not-pressed result carries a coordinate");

  a_x_clamped: assert property (@(posedge clk) disable iff (rst)
    !up_stall && up_valid && up_work.pressed && up_work.x.sel == MAP_DIV
    |=> res.screen_x <= LIM_X)
    else $error("screen_x beyond screen width");

  a_y_clamped: assert property (@(posedge clk) disable iff (rst)
    !up_stall && up_valid && up_work.pressed && up_work.y.sel == MAP_DIV
    |=> res.screen_y <= LIM_Y)
    else $error("screen_y beyond screen height");
`endif

endmodule

// ===== sv/touch_sample_to_screen_point_core.sv =====
// ----------------------------------------------------------------------------
// touch_sample_to_screen_point_core
// Maps one set of touch conversions to a pressed flag and a screen point.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  sample    sample_valid/sample_stall  sample_t (pressure, 3x X, 3x Y)
//  point     point_valid/point_stall    point_t (pressed, screen_x, screen_y)
//  config    cfg_write                  cfg_index, cfg_data
//
//  One request per cycle sustained while point_stall is low; a result passes
//  through 3 prep stages, 11 divide cells and 1 output register.
//  The divide chain produces one quotient bit per cell.
//  rst is synchronous; it clears stage valids and loads config defaults.
//  A stall only holds stages that are full, so bubbles close up behind it.
// ----------------------------------------------------------------------------
module touch_sample_to_screen_point_core import tssp_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  sample_t              sample,
  output logic                 point_valid,
  input  logic                 point_stall,
  output point_t               point
);

  cfg_t cfg;

  logic  c_valid [DIV_STEPS+1];
  logic  c_stall [DIV_STEPS+1];
  work_t c_work  [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.raw_left        <= RST_RAW_LEFT;
      cfg.raw_right       <= RST_RAW_RIGHT;
      cfg.raw_top         <= RST_RAW_TOP;
      cfg.raw_bottom      <= RST_RAW_BOTTOM;
      cfg.anchor_low      <= RST_ANCHOR_LOW;
      cfg.anchor_high_x   <= RST_ANCHOR_HIGH_X;
      cfg.anchor_high_y   <= RST_ANCHOR_HIGH_Y;
      cfg.touch_level     <= RST_TOUCH_LEVEL;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_RAW_LEFT:        cfg.raw_left        <= cfg_data;
        REG_RAW_RIGHT:       cfg.raw_right       <= cfg_data;
        REG_RAW_TOP:         cfg.raw_top         <= cfg_data;
        REG_RAW_BOTTOM:      cfg.raw_bottom      <= cfg_data;
        REG_ANCHOR_LOW:      cfg.anchor_low      <= cfg_data[COORD_W-1:0];
        REG_ANCHOR_HIGH_X:   cfg.anchor_high_x   <= cfg_data[COORD_W-1:0];
        REG_ANCHOR_HIGH_Y:   cfg.anchor_high_y   <= cfg_data[COORD_W-1:0];
        REG_TOUCH_LEVEL:     cfg.touch_level     <= cfg_data;
      endcase
    end
  end

  tssp_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .up_valid  (sample_valid),
    .up_stall  (sample_stall),
    .up_sample (sample),
    .dn_valid  (c_valid[0]),
    .dn_stall  (c_stall[0]),
    .dn_work   (c_work[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    tssp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (c_valid[i]),
      .up_stall (c_stall[i]),
      .up_work  (c_work[i]),
      .dn_valid (c_valid[i+1]),
      .dn_stall (c_stall[i+1]),
      .dn_work  (c_work[i+1])
    );
  end

  tssp_finish #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_finish (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .up_valid    (c_valid[DIV_STEPS]),
    .up_stall    (c_stall[DIV_STEPS]),
    .up_work     (c_work[DIV_STEPS]),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point       (point)
  );

endmodule

// ===== tb/sv/tb_touch_sample_to_screen_point_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_touch_sample_to_screen_point_core
// Self-checking bench for the touch sample to screen point core.
// Sample sets are driven through the valid/stall request channel, and each
// one is run through a behavioral copy of the pressure test, three-sample
// averaging and anchored axis maps. Results are checked in order against it.
// Several calibrations are loaded while idle: reset values, full range,
// reversed/equal anchors, a falling output slope and random settings.
// ----------------------------------------------------------------------------
module tb_touch_sample_to_screen_point_core;
  import tssp_pkg::*;

  localparam int TB_SCREEN_W    = DEF_SCREEN_WIDTH;
  localparam int TB_SCREEN_H    = DEF_SCREEN_HEIGHT;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  class point_checker;
    cfg_t   cal;
    point_t pending_points[$];
    int     mismatches;

    function new();
      mismatches = 0;
      cal.raw_left        = RST_RAW_LEFT;
      cal.raw_right       = RST_RAW_RIGHT;
      cal.raw_top         = RST_RAW_TOP;
      cal.raw_bottom      = RST_RAW_BOTTOM;
      cal.anchor_low      = RST_ANCHOR_LOW;
      cal.anchor_high_x   = RST_ANCHOR_HIGH_X;
      cal.anchor_high_y   = RST_ANCHOR_HIGH_Y;
      cal.touch_level     = RST_TOUCH_LEVEL;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [SAMPLE_W-1:0] d);
      case (idx)
        REG_RAW_LEFT:        cal.raw_left        = d;
        REG_RAW_RIGHT:       cal.raw_right       = d;
        REG_RAW_TOP:         cal.raw_top         = d;
        REG_RAW_BOTTOM:      cal.raw_bottom      = d;
        REG_ANCHOR_LOW:      cal.anchor_low      = d[COORD_W-1:0];
        REG_ANCHOR_HIGH_X:   cal.anchor_high_x   = d[COORD_W-1:0];
        REG_ANCHOR_HIGH_Y:   cal.anchor_high_y   = d[COORD_W-1:0];
        REG_TOUCH_LEVEL:     cal.touch_level     = d;
        default: ;
      endcase
    endfunction

    function int mean_of_three(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                               logic [SAMPLE_W-1:0] c);
      int total;
      total = 0;
      total += a;
      total += b;
      total += c;
      return total / 3;
    endfunction

    // edges give the output anchor as is; the interpolated span is clamped
    function logic [COORD_W-1:0] map_axis(int v, int hi_raw, int lo_raw, int lo_out,
                                          int hi_out, int limit);
      int r;
      if (v >= hi_raw) return COORD_W'(lo_out);
      if (v <= lo_raw) return COORD_W'(hi_out);
      r = lo_out + (hi_raw - v) * (hi_out - lo_out) / (hi_raw - lo_raw);
      if (r < 0) r = 0;
      if (r > limit) r = limit;
      return COORD_W'(r);
    endfunction

    function point_t predict_point(sample_t s);
      point_t p;
      p = '0;
      if (s.pressure_sample < cal.touch_level) return p;
      p.pressed  = 1'b1;
      p.screen_x = map_axis(mean_of_three(s.y_sample_a, s.y_sample_b, s.y_sample_c),
                            cal.raw_left, cal.raw_right, cal.anchor_low,
                            cal.anchor_high_x, TB_SCREEN_W - 1);
      p.screen_y = map_axis(mean_of_three(s.x_sample_a, s.x_sample_b, s.x_sample_c),
                            cal.raw_top, cal.raw_bottom, cal.anchor_low,
                            cal.anchor_high_y, TB_SCREEN_H - 1);
      return p;
    endfunction

    function void note_sample(sample_t s);
      pending_points.push_back(predict_point(s));
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (pending_points.size() == 0) begin
        $error("point: result with no request outstanding");
        mismatches++;
        return;
      end
      want = pending_points.pop_front();
      if (got.pressed !== want.pressed) begin
        $error("pressed: expected %0d, got %0d", want.pressed, got.pressed);
        mismatches++;
      end
      if (got.screen_x !== want.screen_x) begin
        $error("screen_x: expected %0d, got %0d", want.screen_x, got.screen_x);
        mismatches++;
      end
      if (got.screen_y !== want.screen_y) begin
        $error("screen_y: expected %0d, got %0d", want.screen_y, got.screen_y);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SAMPLE_W-1:0]  cfg_data;
  logic                 sample_valid;
  logic                 sample_stall;
  sample_t              sample;
  logic                 point_valid;
  logic                 point_stall;
  point_t               point;

  point_checker board = new();
  int tx_gap_pct;
  int rx_stall_pct;
  int hold_cycles;
  int quiet_cycles;

  touch_sample_to_screen_point_core #(
    .SCREEN_WIDTH (TB_SCREEN_W),
    .SCREEN_HEIGHT(TB_SCREEN_H)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point       (point)
  );

  always #2 clk = ~clk;

  function automatic int gap_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int jitter(int span);
    int j;
    j = $urandom_range(0, 2 * span);
    return j - span;
  endfunction

  function automatic logic [SAMPLE_W-1:0] clip12(int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return SAMPLE_W'(v);
  endfunction

  function automatic sample_t make_sample(int p, int xa, int xb, int xc,
                                          int ya, int yb, int yc);
    sample_t s;
    s.pressure_sample = clip12(p);
    s.x_sample_a = clip12(xa);
    s.x_sample_b = clip12(xb);
    s.x_sample_c = clip12(xc);
    s.y_sample_a = clip12(ya);
    s.y_sample_b = clip12(yb);
    s.y_sample_c = clip12(yc);
    return s;
  endfunction

  function automatic cfg_t calibration(int rl, int rr, int rt, int rb,
                                       int al, int ahx, int ahy, int thr);
    cfg_t c;
    c.raw_left        = SAMPLE_W'(rl);
    c.raw_right       = SAMPLE_W'(rr);
    c.raw_top         = SAMPLE_W'(rt);
    c.raw_bottom      = SAMPLE_W'(rb);
    c.anchor_low      = COORD_W'(al);
    c.anchor_high_x   = COORD_W'(ahx);
    c.anchor_high_y   = COORD_W'(ahy);
    c.touch_level     = SAMPLE_W'(thr);
    return c;
  endfunction

  function automatic cfg_t rand_calibration();
    cfg_t c;
    c.raw_left        = SAMPLE_W'($urandom_range(2048, 4095));
    c.raw_right       = SAMPLE_W'($urandom_range(0, 2047));
    c.raw_top         = SAMPLE_W'($urandom_range(2048, 4095));
    c.raw_bottom      = SAMPLE_W'($urandom_range(0, 2047));
    c.anchor_low      = ($urandom_range(0, 1) != 0) ? COORD_W'($urandom_range(0, 40))
                                                     : COORD_W'($urandom_range(0, 2047));
    c.anchor_high_x   = COORD_W'($urandom_range(0, 2047));
    c.anchor_high_y   = COORD_W'($urandom_range(0, 2047));
    c.touch_level     = SAMPLE_W'($urandom_range(0, 4095));
    if ($urandom_range(0, 99) < 20) begin
      c.raw_left   = SAMPLE_W'($urandom_range(0, 4095));
      c.raw_bottom = SAMPLE_W'($urandom_range(0, 4095));
    end
    return c;
  endfunction

  // three samples of one channel, often clustered on a calibration anchor
  function automatic void pick_channel(int hi_raw, int lo_raw, output logic [SAMPLE_W-1:0] a,
                                       output logic [SAMPLE_W-1:0] b,
                                       output logic [SAMPLE_W-1:0] c);
    int mode;
    int centre;
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      a = SAMPLE_W'($urandom_range(0, 4095));
      b = SAMPLE_W'($urandom_range(0, 4095));
      c = SAMPLE_W'($urandom_range(0, 4095));
    end else if (mode < 7) begin
      centre = (($urandom_range(0, 1) != 0) ? hi_raw : lo_raw) + jitter(3);
      a = clip12(centre + jitter(1));
      b = clip12(centre + jitter(1));
      c = clip12(centre + jitter(1));
    end else if (mode < 8) begin
      a = ($urandom_range(0, 1) != 0) ? '1 : '0;
      b = ($urandom_range(0, 1) != 0) ? '1 : '0;
      c = ($urandom_range(0, 1) != 0) ? '1 : '0;
    end else begin
      centre = $urandom_range(0, 4095);
      a = clip12(centre + jitter(8));
      b = clip12(centre + jitter(8));
      c = clip12(centre + jitter(8));
    end
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 3) s.pressure_sample = clip12(int'(board.cal.touch_level) + jitter(2));
    else if (mode < 4) s.pressure_sample = ($urandom_range(0, 1) != 0) ? '1 : '0;
    else s.pressure_sample = SAMPLE_W'($urandom_range(0, 4095));
    pick_channel(board.cal.raw_top, board.cal.raw_bottom,
                 s.x_sample_a, s.x_sample_b, s.x_sample_c);
    pick_channel(board.cal.raw_left, board.cal.raw_right,
                 s.y_sample_a, s.y_sample_b, s.y_sample_c);
    return s;
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic offer_sample(input sample_t s);
    int gap;
    sample       <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    board.note_sample(s);
    @(negedge clk);
    gap = 0;
    if ($urandom_range(0, 99) < tx_gap_pct) gap = gap_length();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic run_random(input int count);
    repeat (count) offer_sample(rand_sample());
  endtask

  task automatic settle();
    sample_valid <= 1'b0;
    while (board.pending_points.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_calibration(input cfg_t c);
    cfg_reg_e            idx;
    logic [SAMPLE_W-1:0] d;
    for (int i = 0; i <= int'(REG_TOUCH_LEVEL); i++) begin
      idx = cfg_reg_e'(i);
      case (idx)
        REG_RAW_LEFT:      d = c.raw_left;
        REG_RAW_RIGHT:     d = c.raw_right;
        REG_RAW_TOP:       d = c.raw_top;
        REG_RAW_BOTTOM:    d = c.raw_bottom;
        REG_ANCHOR_LOW:    d = {1'b0, c.anchor_low};
        REG_ANCHOR_HIGH_X: d = {1'b0, c.anchor_high_x};
        REG_ANCHOR_HIGH_Y: d = {1'b0, c.anchor_high_y};
        default:           d = c.touch_level;
      endcase
      // junk in the unused top bit of the coordinate registers
      if (idx inside {REG_ANCHOR_LOW, REG_ANCHOR_HIGH_X, REG_ANCHOR_HIGH_Y})
        d[SAMPLE_W-1] = 1'($urandom_range(0, 1));
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= d;
      @(posedge clk);
      board.write_reg(idx, d);
      @(negedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // reset calibration: X/Y raw edges 3800/300, threshold 100
  task automatic directed_edges();
    offer_sample(make_sample(0, 2000, 2000, 2000, 2000, 2000, 2000));
    offer_sample(make_sample(99, 2000, 2000, 2000, 2000, 2000, 2000));
    offer_sample(make_sample(100, 2000, 2000, 2000, 2000, 2000, 2000));
    offer_sample(make_sample(4095, 4095, 4095, 4095, 4095, 4095, 4095));
    offer_sample(make_sample(4095, 0, 0, 0, 0, 0, 0));
    offer_sample(make_sample(0, 4095, 4095, 4095, 4095, 4095, 4095));
    offer_sample(make_sample(200, 3800, 3800, 3800, 300, 300, 300));
    offer_sample(make_sample(200, 300, 300, 300, 3800, 3800, 3800));
    offer_sample(make_sample(200, 3799, 3799, 3799, 301, 301, 301));
    offer_sample(make_sample(200, 301, 301, 301, 3799, 3799, 3799));
    offer_sample(make_sample(200, 3800, 3800, 3801, 3799, 3800, 3800));
    offer_sample(make_sample(200, 299, 300, 302, 300, 300, 301));
    offer_sample(make_sample(200, 0, 4095, 4095, 4095, 0, 0));
    offer_sample(make_sample(4095, 2050, 2050, 2050, 1234, 1235, 1236));
    offer_sample(make_sample(100, 1, 2, 2, 4094, 4094, 4095));
    offer_sample(make_sample(2730, 1365, 2730, 1365, 2730, 1365, 2730));
  endtask

  always @(posedge clk) begin
    if (!rst && point_valid && !point_stall) board.check_point(point);
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (point_valid && !point_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_touch_sample_to_screen_point_core: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int run_left;
    run_left    = 0;
    point_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        run_left    = hold_cycles;
        hold_cycles = 0;
      end else if (run_left == 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        run_left = gap_length();
      end
      if (run_left > 0) begin
        point_stall <= 1'b1;
        run_left--;
      end else begin
        point_stall <= 1'b0;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = REG_RAW_LEFT;
    cfg_data     = '0;
    sample_valid = 1'b0;
    sample       = '0;
    tx_gap_pct   = 30;
    rx_stall_pct = 20;
    hold_cycles  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_edges();
    run_random(234);

    // back up the output until the input stalls
    tx_gap_pct  = 0;
    hold_cycles = HOLD_CYCLES;
    run_random(60);
    tx_gap_pct  = 30;

    // full range anchors, always pressed, no idling
    settle();
    load_calibration(calibration(4095, 0, 4095, 0, 0, 2047, 2047, 0));
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    run_random(200);
    tx_gap_pct   = 30;
    rx_stall_pct = 20;

    // reversed X anchors, equal Y raw edges, only full pressure counts
    settle();
    load_calibration(calibration(100, 3000, 0, 0, 2047, 0, 5, 4095));
    run_random(150);

    // falling output slope; sender waits for the pipe to empty midway
    settle();
    load_calibration(calibration(3500, 500, 3000, 1000, 300, 10, 200, 2000));
    run_random(100);
    settle();
    run_random(100);

    repeat (3) begin
      settle();
      load_calibration(rand_calibration());
      run_random(200);
    end

    settle();
    if (board.mismatches == 0) begin
      $display("tb_touch_sample_to_screen_point_core: done, clean");
    end else begin
      $display("tb_touch_sample_to_screen_point_core: done, errors");
    end
    $finish;
  end

endmodule

// ===== touch_sample_to_screen_point_core.f =====
sv/tssp_pkg.sv
sv/tssp_prep.sv
sv/tssp_cell.sv
sv/tssp_finish.sv
sv/touch_sample_to_screen_point_core.sv
tb/sv/tb_touch_sample_to_screen_point_core.sv
